FILE: hw/rtl/mnds_pkg.sv
// mnds_pkg: shared constants and types for the max neighbour difference scan.
// Used by the scan, pair-select and best-track modules and by the checker, not by the RAM; depends on nothing.
package mnds_pkg;

	localparam int DEF_MAX_COLUMNS  = 1024;
	localparam int DEF_MAX_ROWS     = 1024;
	localparam int DEF_ELEMENT_BITS = 16;

	localparam int LEN_BITS = 11;
	localparam int POS_BITS = 10;
	localparam int VAL_BITS = 16;

	localparam logic [LEN_BITS-1:0] ROW_LENGTH_RESET = LEN_BITS'(1024);
	localparam logic [VAL_BITS-1:0] DIFF_SAT         = {VAL_BITS{1'b1}};

	// result tdata layout, lowest bit first
	localparam int MAXD_LSB  = 0;
	localparam int CROW_LSB  = MAXD_LSB + VAL_BITS;
	localparam int CCOL_LSB  = CROW_LSB + POS_BITS;
	localparam int CVAL_LSB  = CCOL_LSB + POS_BITS;
	localparam int NROW_LSB  = CVAL_LSB + VAL_BITS;
	localparam int NCOL_LSB  = NROW_LSB + POS_BITS;
	localparam int NVAL_LSB  = NCOL_LSB + POS_BITS;
	localparam int OUT_FIELDS_W = NVAL_LSB + VAL_BITS;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef struct packed {
		logic [POS_BITS-1:0] center_row;
		logic [POS_BITS-1:0] center_col;
		logic [VAL_BITS-1:0] center_value;
		logic [POS_BITS-1:0] neighbour_row;
		logic [POS_BITS-1:0] neighbour_col;
		logic [VAL_BITS-1:0] neighbour_value;
	} pair_info_t;

endpackage

FILE: hw/rtl/mnds_ram.sv
// mnds_ram: generic single-write, single-read RAM with registered read data.
// Read-first on a same-address read and write. No dependencies.
module mnds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

FILE: hw/rtl/mnds_pair_select.sv
// mnds_pair_select: absolute differences against the upper-left, upper and left
// neighbours and the element itself; picks the first largest. Uses mnds_pkg.
module mnds_pair_select import mnds_pkg::*; #(
	parameter int ELEMENT_BITS = DEF_ELEMENT_BITS,
	parameter int ROW_W        = 10,
	parameter int COL_W        = 10
) (
	input  logic signed [ELEMENT_BITS-1:0] center,
	input  logic signed [ELEMENT_BITS-1:0] up,
	input  logic signed [ELEMENT_BITS-1:0] upper_left,
	input  logic signed [ELEMENT_BITS-1:0] left,
	input  logic [ROW_W-1:0]               row,
	input  logic [COL_W-1:0]               col,
	output logic [ELEMENT_BITS:0]          diff,
	output pair_info_t                     info
);

	localparam int DIFF_W = ELEMENT_BITS + 1;

	logic signed [DIFF_W-1:0]       d_ul, d_up, d_left;
	logic [DIFF_W-1:0]              a_ul, a_up, a_left;
	logic                           has_up, has_left, has_ul;
	logic                           pa_ok, pa_is_ul;
	logic [DIFF_W-1:0]              pa_diff, pb_diff;
	logic signed [ELEMENT_BITS-1:0] pa_val, pb_val, nb_val;
	logic [COL_W-1:0]               pa_col, pb_col, nb_col;
	logic [ROW_W-1:0]               row_m1, pb_row, nb_row;
	logic                           take_a;

	assign d_ul   = DIFF_W'(center) - DIFF_W'(upper_left);
	assign d_up   = DIFF_W'(center) - DIFF_W'(up);
	assign d_left = DIFF_W'(center) - DIFF_W'(left);

	assign a_ul   = d_ul[DIFF_W-1]   ? DIFF_W'(-d_ul)   : DIFF_W'(d_ul);
	assign a_up   = d_up[DIFF_W-1]   ? DIFF_W'(-d_up)   : DIFF_W'(d_up);
	assign a_left = d_left[DIFF_W-1] ? DIFF_W'(-d_left) : DIFF_W'(d_left);

	assign has_up   = (row != '0);
	assign has_left = (col != '0);
	assign has_ul   = has_up && has_left;
	assign row_m1   = row - ROW_W'(1);

	// upper pair: upper-left wins ties
	assign pa_ok    = has_up;
	assign pa_is_ul = has_ul && !(a_up > a_ul);
	assign pa_diff  = pa_is_ul ? a_ul : a_up;
	assign pa_val   = pa_is_ul ? upper_left : up;
	assign pa_col   = pa_is_ul ? col - COL_W'(1) : col;

	// same-row pair: self (difference zero) never beats left
	assign pb_diff = has_left ? a_left : '0;
	assign pb_val  = has_left ? left : center;
	assign pb_col  = has_left ? col - COL_W'(1) : col;
	assign pb_row  = row;

	assign take_a = pa_ok && !(pb_diff > pa_diff);

	assign diff   = take_a ? pa_diff : pb_diff;
	assign nb_val = take_a ? pa_val : pb_val;
	assign nb_col = take_a ? pa_col : pb_col;
	assign nb_row = take_a ? row_m1 : pb_row;

	always_comb begin
		info.center_row      = POS_BITS'(row);
		info.center_col      = POS_BITS'(col);
		info.center_value    = VAL_BITS'(center);
		info.neighbour_row   = POS_BITS'(nb_row);
		info.neighbour_col   = POS_BITS'(nb_col);
		info.neighbour_value = VAL_BITS'(nb_val);
	end

endmodule

FILE: hw/rtl/mnds_best_track.sv
// mnds_best_track: running maximum per matrix and the result output register.
// Uses mnds_pkg for the result layout.
module mnds_best_track import mnds_pkg::*; #(
	parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s2,
	input  logic                  last_s2,
	input  logic [ELEMENT_BITS:0] diff_s2,
	input  pair_info_t            info_s2,
	output logic                  adv,
	input  logic                  m_axis_tready,
	output logic                  m_axis_tvalid,
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int DIFF_W = ELEMENT_BITS + 1;
	localparam int WIDE_W = DIFF_W > VAL_BITS ? DIFF_W : VAL_BITS;

	logic              found_q;
	logic [DIFF_W-1:0] best_q, best_nxt;
	pair_info_t        info_q, info_nxt;
	logic              take;
	logic [WIDE_W-1:0] best_wide;
	logic [VAL_BITS-1:0] best_sat;

	assign adv  = !m_axis_tvalid || m_axis_tready;
	assign take = !found_q || (diff_s2 > best_q);

	assign best_nxt = take ? diff_s2 : best_q;
	assign info_nxt = take ? info_s2 : info_q;

	assign best_wide = WIDE_W'(best_nxt);
	assign best_sat  = (best_wide > WIDE_W'(DIFF_SAT)) ? DIFF_SAT : VAL_BITS'(best_wide);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (adv && valid_s2) begin
			found_q <= !last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			best_q <= best_nxt;
			info_q <= info_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && last_s2) begin
			m_axis_tdata <= OUT_DATA_W'({info_nxt.neighbour_value, info_nxt.neighbour_col,
				info_nxt.neighbour_row, info_nxt.center_value, info_nxt.center_col,
				info_nxt.center_row, best_sat});
		end
	end

endmodule

FILE: hw/rtl/max_neighbour_difference_scan.sv
// Max neighbour difference scan. Takes one matrix element per clock in raster
// order while s_axis_tready is high, and emits one result per matrix after its
// tlast element passes stages 1 and 2 into the output register. s_axis_tready
// drops only while a result waits in the output register. The previous row
// sits in a MAX_COLUMNS-deep RAM read and written once per element at the
// element's column; row length 0 acts as 1, above MAX_COLUMNS as MAX_COLUMNS.
module max_neighbour_difference_scan import mnds_pkg::*; #(
	parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS     = DEF_MAX_ROWS,
	parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  row_length_we,
	input  logic [LEN_BITS-1:0]                   row_length,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// element_value, zero padded to whole bytes
	input  logic [((ELEMENT_BITS+7)/8)*8-1:0]     s_axis_tdata,
	// end_of_matrix
	input  logic                                  s_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// max_difference, center_row, center_col, center_value,
	// neighbour_row, neighbour_col, neighbour_value
	output logic [OUT_DATA_W-1:0]                 m_axis_tdata
);

	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int ROW_W = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int LW    = COL_W + 1;
	localparam int CMP_W = LW > LEN_BITS ? LW : LEN_BITS;
	localparam int DIFF_W = ELEMENT_BITS + 1;

	logic [LEN_BITS-1:0] row_length_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [CMP_W-1:0]    len_cfg, len_eff, col_next;
	logic                wrap, acc, adv;

	logic signed [ELEMENT_BITS-1:0] v_in;
	logic [ELEMENT_BITS-1:0]        up_rd;

	logic                           valid_s1, last_s1;
	logic signed [ELEMENT_BITS-1:0] v_s1;
	logic [ROW_W-1:0]               row_s1;
	logic [COL_W-1:0]               col_s1;
	logic signed [ELEMENT_BITS-1:0] ul_q, left_q;

	logic              valid_s2, last_s2;
	logic [DIFF_W-1:0] diff_s1, diff_s2;
	pair_info_t        info_s1, info_s2;

	assign v_in          = s_axis_tdata[ELEMENT_BITS-1:0];
	assign s_axis_tready = adv;
	assign acc           = s_axis_tvalid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
		end else if (row_length_we) begin
			row_length_q <= row_length;
		end
	end

	assign len_cfg  = CMP_W'(row_length_q);
	assign len_eff  = (len_cfg == '0) ? CMP_W'(1) :
		(len_cfg > CMP_W'(MAX_COLUMNS)) ? CMP_W'(MAX_COLUMNS) : len_cfg;
	assign col_next = CMP_W'(col_q) + CMP_W'(1);
	assign wrap     = (col_next >= len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (s_axis_tlast) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				if (row_q != ROW_W'(MAX_ROWS - 1)) begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= COL_W'(col_next);
			end
		end
	end

	mnds_ram #(
		.WIDTH(ELEMENT_BITS),
		.DEPTH(MAX_COLUMNS)
	) u_line (
		.clk  (clk),
		.we   (acc),
		.waddr(col_q),
		.wdata(v_in),
		.re   (acc),
		.raddr(col_q),
		.rdata(up_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			v_s1    <= v_in;
			last_s1 <= s_axis_tlast;
			row_s1  <= row_q;
			col_s1  <= col_q;
		end
		if (adv && valid_s1) begin
			ul_q    <= up_rd;
			left_q  <= v_s1;
			diff_s2 <= diff_s1;
			info_s2 <= info_s1;
			last_s2 <= last_s1;
		end
	end

	mnds_pair_select #(
		.ELEMENT_BITS(ELEMENT_BITS),
		.ROW_W       (ROW_W),
		.COL_W       (COL_W)
	) u_select (
		.center    (v_s1),
		.up        (up_rd),
		.upper_left(ul_q),
		.left      (left_q),
		.row       (row_s1),
		.col       (col_s1),
		.diff      (diff_s1),
		.info      (info_s1)
	);

	mnds_best_track #(
		.ELEMENT_BITS(ELEMENT_BITS)
	) u_best (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s2     (valid_s2),
		.last_s2      (last_s2),
		.diff_s2      (diff_s2),
		.info_s2      (info_s2),
		.adv          (adv),
		.m_axis_tready(m_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

FILE: hw/rtl/mnds_checker.sv
// mnds_checker: port-level assertions for max_neighbour_difference_scan,
// bound to the top level below. Uses mnds_pkg for the result layout.
module mnds_checker import mnds_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a waiting result");

	a_zero_diff_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[MAXD_LSB +: VAL_BITS] == '0)
		|-> m_axis_tdata[CVAL_LSB +: VAL_BITS] == m_axis_tdata[NVAL_LSB +: VAL_BITS])
		else $error("zero difference with unequal values");

endmodule

bind max_neighbour_difference_scan mnds_checker u_mnds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
